[sv/svm_pkg.sv]
`timescale 1ns / 1ps
// svm_pkg: shared widths, codes and handshake structs for the sphere voxel marker
// no dependencies; imported by every module of the block but svm_ram

package svm_pkg;

    // field and register widths
    localparam int COORD_W    = 16;
    localparam int LEN_W      = 15;
    localparam int RAD_W      = 15;
    localparam int FUNC_W     = 2;
    localparam int RIDX_W     = 6;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // stream payload layout
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;
    localparam int CX_LSB    = 0;
    localparam int CY_LSB    = 16;
    localparam int CZ_LSB    = 32;
    localparam int RX_LSB    = 48;
    localparam int RY_LSB    = 54;
    localparam int RZ_LSB    = 60;

    // bounding box division: (c - origin +/- r) needs 18 signed bits
    localparam int DIV_W     = 18;
    localparam int MAG_W     = DIV_W - 1;
    localparam int DIV_CNT_W = 5;

    // corner offsets stay below r + 2*len in magnitude
    localparam int D_W   = 18;
    localparam int SQ_W  = 2 * D_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int R2_W  = 2 * RAD_W;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LENGTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS = 2'd2;

    // register reset values
    localparam logic signed [COORD_W-1:0] ORIGIN_RST = -16'sd8192;
    localparam logic [LEN_W-1:0]          LENGTH_RST = 15'd256;
    localparam logic [RAD_W-1:0]          RADIUS_RST = 15'd768;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] numer;
        logic [LEN_W-1:0]        denom;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [DIV_W-1:0] quot;
    } div_rsp_t;

endpackage

[sv/svm_ram.sv]
`timescale 1ns / 1ps
// svm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module svm_ram #(
    parameter  int WIDTH  = 64,
    parameter  int DEPTH  = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/svm_divider.sv]
`timescale 1ns / 1ps
// svm_divider: signed by unsigned restoring divider, quotient truncated toward zero
// depends on svm_pkg (div_req_t, div_rsp_t, widths)

module svm_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  svm_pkg::div_req_t req,
    output svm_pkg::div_rsp_t rsp
);
    import svm_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(MAG_W - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        num_reg;
    logic [LEN_W-1:0]        rem_reg;
    logic [LEN_W-1:0]        den_reg;
    logic signed [DIV_W-1:0] quot_reg;

    logic signed [DIV_W-1:0] abs_num;
    logic [LEN_W:0]          trial;
    logic [LEN_W:0]          diff;
    logic                    ge;
    logic [LEN_W-1:0]        rem_next;
    logic [MAG_W-1:0]        num_next;

    assign abs_num  = req.numer[DIV_W-1] ? -req.numer : req.numer;
    assign trial    = {rem_reg, num_reg[MAG_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
    assign num_next = {num_reg[MAG_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            neg_reg <= req.numer[DIV_W-1];
            num_reg <= abs_num[MAG_W-1:0];
            rem_reg <= '0;
            den_reg <= req.denom;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            if (cnt_reg == CNT_LAST)
            begin
                quot_reg <= neg_reg ? -$signed({1'b0, num_next}) : $signed({1'b0, num_next});
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

[sv/sphere_voxel_marker_unit.sv]
`timescale 1ns / 1ps
// sphere_voxel_marker_unit: top level, sequencer around the occupancy row memory
// depends on svm_pkg, svm_ram and svm_divider
//
// usage
//   s_axis carries one item per transaction, its kind in tuser: mark a sphere
//   around an atom centre, read one voxel bit, or clear the whole map. every
//   item gives exactly one m_axis transaction: tuser echoes the kind, tdata[0]
//   is the voxel bit for a read and 0 otherwise.
//   the map lives in one ram of GRID_DIM-bit rows, one row per (x, y) pair,
//   z selecting the bit inside the row.
//   read: the row is read on acceptance, S_READ takes its bit, S_DONE the result.
//   clear: one row written per cycle over all 2**(2*ceil(log2(GRID_DIM)))
//     rows (4096 at the default size), then the result.
//   mark: six box-bound divisions, one after another in the shared
//     divider, then box clamping and per-axis corner setup, then per row of
//     the box a read-modify-write that walks z (a new x first squares dx).
//   one item at a time: s_axis_tready is high only while the sequencer idles.
//   after reset the same clearing pass runs before the first item is taken;
//   configuration writes are taken at any time.
//   the result sits in an output register, so a stalled m_axis does not hold
//   up acceptance of the next item; only the following result waits for it.

module sphere_voxel_marker_unit #(
    parameter int GRID_DIM = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // center_x[15:0], center_y[31:16], center_z[47:32], read_x[53:48],
    // read_y[59:54], read_z[65:60], zero fill to 72 bits
    input  logic [svm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // func[1:0]
    input  logic [svm_pkg::FUNC_W-1:0]        s_axis_tuser,
    // result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // occupied[0], zero fill to 8 bits
    output logic [svm_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // done_kind[1:0]
    output logic [svm_pkg::FUNC_W-1:0]        m_axis_tuser,
    // register write port
    input  logic                              cfg_we,
    input  logic [svm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [svm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import svm_pkg::*;

    localparam int IDX_W   = $clog2(GRID_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int PROD_W  = LEN_W + IDX_W;
    localparam int FULL_W  = PROD_W + 2;

    localparam logic [ADDR_W-1:0]      ADDR_LAST = '1;
    localparam logic signed [DIV_W-1:0] BOX_MAX  = DIV_W'(GRID_DIM - 1);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_READ  = 12'b0000_0000_0100,
        S_DIV   = 12'b0000_0000_1000,
        S_BOX   = 12'b0000_0001_0000,
        S_START = 12'b0000_0010_0000,
        S_XSQ   = 12'b0000_0100_0000,
        S_ROW   = 12'b0000_1000_0000,
        S_SXY   = 12'b0001_0000_0000,
        S_ZWALK = 12'b0010_0000_0000,
        S_WB    = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic signed [COORD_W-1:0] origin_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [RAD_W-1:0]          rad_reg;

    // item held while it is worked on
    logic [FUNC_W-1:0]         func_reg;
    logic signed [COORD_W-1:0] cen_reg [3];
    logic [IDX_W-1:0]          rd_z_reg;
    logic                      rd_ok_reg;
    logic                      occ_reg;
    logic [R2_W-1:0]           r2_reg;

    // clearing sweep
    logic [ADDR_W-1:0]         clr_cnt_reg;
    logic                      clr_item_reg;

    // box bounds
    logic [1:0]                axis_reg;
    logic                      side_reg;
    logic                      div_wait_reg;
    logic signed [DIV_W-1:0]   bnd_lo_reg [3];
    logic signed [DIV_W-1:0]   bnd_hi_reg [3];
    logic [IDX_W-1:0]          lo_idx_reg [3];
    logic [IDX_W-1:0]          hi_idx_reg [3];

    // walk over the box
    logic [IDX_W-1:0]          x_reg;
    logic [IDX_W-1:0]          y_reg;
    logic [IDX_W-1:0]          z_reg;
    logic signed [D_W-1:0]     dx_reg;
    logic signed [D_W-1:0]     dy_reg;
    logic signed [D_W-1:0]     dy0_reg;
    logic signed [D_W-1:0]     dz_reg;
    logic signed [D_W-1:0]     dz0_reg;
    logic [SQ_W-1:0]           dx2_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [SQ_W:0]             sxy_reg;
    logic                      zi_done_reg;
    logic                      p1_valid_reg;
    logic [IDX_W-1:0]          p1_z_reg;
    logic [GRID_DIM-1:0]       mask_reg;

    // result register
    logic                      out_valid_reg;
    logic                      out_occ_reg;
    logic [FUNC_W-1:0]         out_kind_reg;

    // input fields
    logic [FUNC_W-1:0]         in_func;
    logic [RIDX_W-1:0]         in_rx;
    logic [RIDX_W-1:0]         in_ry;
    logic [RIDX_W-1:0]         in_rz;
    logic                      s_accept;
    logic                      out_free;

    // divider handshake
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;
    logic signed [DIV_W-1:0]   rel;
    logic signed [DIV_W-1:0]   rad_s;

    // box clamp
    logic signed [DIV_W-1:0]   lo_c [3];
    logic signed [DIV_W-1:0]   hi_c [3];
    logic [2:0]                empty_ax;
    logic                      box_empty;

    // corner offset at the box start
    logic [PROD_W-1:0]         start_prod;
    logic signed [FULL_W-1:0]  d_full;
    logic signed [D_W-1:0]     d_start;
    logic signed [D_W-1:0]     len_s;

    // shared squarer and sphere test
    logic signed [D_W-1:0]     sq_in;
    logic signed [SQ_W-1:0]    sq_prod;
    logic                      hit;

    // row memory port
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [GRID_DIM-1:0]       ram_wdata;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [GRID_DIM-1:0]       ram_rdata;

    assign in_func = s_axis_tuser;
    assign in_rx   = s_axis_tdata[RX_LSB +: RIDX_W];
    assign in_ry   = s_axis_tdata[RY_LSB +: RIDX_W];
    assign in_rz   = s_axis_tdata[RZ_LSB +: RIDX_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // bound numerators: c - origin - r for the low side, c - origin + r for the high side
    assign rel   = DIV_W'(cen_reg[axis_reg]) - DIV_W'(origin_reg);
    assign rad_s = $signed({{(DIV_W - RAD_W){1'b0}}, rad_reg});

    assign div_req.start = (state_reg == S_DIV) && !div_wait_reg;
    assign div_req.numer = side_reg ? rel + rad_s : rel - rad_s;
    assign div_req.denom = len_reg;

    svm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // clamp each axis to the grid; any empty axis ends the mark
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_c[k]     = (bnd_lo_reg[k] < 0) ? '0 : bnd_lo_reg[k];
            hi_c[k]     = (bnd_hi_reg[k] > BOX_MAX) ? BOX_MAX : bnd_hi_reg[k];
            empty_ax[k] = lo_c[k] > hi_c[k];
        end
    end
    assign box_empty = |empty_ax;

    // origin + len * lo - c for the axis under setup
    assign start_prod = len_reg * lo_idx_reg[axis_reg];
    assign d_full     = FULL_W'(origin_reg) + FULL_W'($signed({1'b0, start_prod}))
                        - FULL_W'(cen_reg[axis_reg]);
    assign d_start    = D_W'(d_full);
    assign len_s      = $signed({{(D_W - LEN_W){1'b0}}, len_reg});

    // one squarer serves dx, dy and the z walk in turn
    always_comb
    begin
        priority if (state_reg == S_XSQ)
        begin
            sq_in = dx_reg;
        end
        else if (state_reg == S_ROW)
        begin
            sq_in = dy_reg;
        end
        else
        begin
            sq_in = dz_reg;
        end
    end
    assign sq_prod = sq_in * sq_in;
    assign hit     = (SUM_W'(sxy_reg) + SUM_W'(sq_reg)) <= SUM_W'(r2_reg);

    // memory port: clear sweep and row write-back share the write side;
    // rows are distinct within a mark and the write lands before the next item,
    // so a read never overlaps a pending write of the same row
    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_WB);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : {x_reg, y_reg};
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : (ram_rdata | mask_reg);
    assign ram_re    = (s_accept && (in_func == FUNC_READ)) || (state_reg == S_ROW);
    assign ram_raddr = (state_reg == S_ROW) ? {x_reg, y_reg}
                                            : {IDX_W'(in_rx), IDX_W'(in_ry)};

    svm_ram #(
        .WIDTH (GRID_DIM),
        .DEPTH (RAM_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_LAST)
                begin
                    state_next = clr_item_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (in_func)
                        FUNC_MARK:  state_next = (len_reg == '0) ? S_DONE : S_DIV;
                        FUNC_READ:  state_next = S_READ;
                        FUNC_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_wait_reg && div_rsp.done && side_reg && (axis_reg == AXIS_Z))
                begin
                    state_next = S_BOX;
                end
            end
            S_BOX:
            begin
                state_next = box_empty ? S_DONE : S_START;
            end
            S_START:
            begin
                if (axis_reg == AXIS_Z)
                begin
                    state_next = S_XSQ;
                end
            end
            S_XSQ:
            begin
                state_next = S_ROW;
            end
            S_ROW:
            begin
                state_next = S_SXY;
            end
            S_SXY:
            begin
                state_next = S_ZWALK;
            end
            S_ZWALK:
            begin
                if (zi_done_reg && !p1_valid_reg)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (y_reg == hi_idx_reg[1])
                begin
                    state_next = (x_reg == hi_idx_reg[0]) ? S_DONE : S_XSQ;
                end
                else
                begin
                    state_next = S_ROW;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            origin_reg    <= ORIGIN_RST;
            len_reg       <= LENGTH_RST;
            rad_reg       <= RADIUS_RST;
            clr_cnt_reg   <= '0;
            clr_item_reg  <= 1'b0;
            axis_reg      <= AXIS_X;
            side_reg      <= 1'b0;
            div_wait_reg  <= 1'b0;
            zi_done_reg   <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_ORIGIN: origin_reg <= $signed(cfg_wdata);
                    REG_LENGTH: len_reg    <= cfg_wdata[LEN_W-1:0];
                    REG_RADIUS: rad_reg    <= cfg_wdata[RAD_W-1:0];
                    default:    ;
                endcase
            end

            // result register: a new result loads only once the old one is taken
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_LAST)
                    begin
                        clr_item_reg <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        clr_cnt_reg  <= '0;
                        clr_item_reg <= (in_func == FUNC_CLEAR);
                        axis_reg     <= AXIS_X;
                        side_reg     <= 1'b0;
                        div_wait_reg <= 1'b0;
                    end
                end
                S_DIV:
                begin
                    if (!div_wait_reg)
                    begin
                        div_wait_reg <= 1'b1;
                    end
                    else if (div_rsp.done)
                    begin
                        div_wait_reg <= 1'b0;
                        side_reg     <= !side_reg;
                        if (side_reg)
                        begin
                            axis_reg <= (axis_reg == AXIS_Z) ? AXIS_X : axis_reg + 1'b1;
                        end
                    end
                end
                S_START:
                begin
                    axis_reg <= (axis_reg == AXIS_Z) ? AXIS_X : axis_reg + 1'b1;
                end
                S_SXY:
                begin
                    zi_done_reg  <= 1'b0;
                    p1_valid_reg <= 1'b0;
                end
                S_ZWALK:
                begin
                    p1_valid_reg <= !zi_done_reg;
                    if (!zi_done_reg && (z_reg == hi_idx_reg[2]))
                    begin
                        zi_done_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_occ_reg  <= occ_reg;
            out_kind_reg <= func_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    func_reg   <= in_func;
                    cen_reg[0] <= $signed(s_axis_tdata[CX_LSB +: COORD_W]);
                    cen_reg[1] <= $signed(s_axis_tdata[CY_LSB +: COORD_W]);
                    cen_reg[2] <= $signed(s_axis_tdata[CZ_LSB +: COORD_W]);
                    rd_z_reg   <= IDX_W'(in_rz);
                    // indices beyond a small grid read as empty
                    rd_ok_reg  <= (32'(in_rx) < GRID_DIM) && (32'(in_ry) < GRID_DIM)
                                  && (32'(in_rz) < GRID_DIM);
                    occ_reg    <= 1'b0;
                    r2_reg     <= rad_reg * rad_reg;
                end
            end
            S_READ:
            begin
                occ_reg <= rd_ok_reg && ram_rdata[rd_z_reg];
            end
            S_DIV:
            begin
                if (div_wait_reg && div_rsp.done)
                begin
                    if (side_reg)
                    begin
                        bnd_hi_reg[axis_reg] <= div_rsp.quot + DIV_W'(1);
                    end
                    else
                    begin
                        bnd_lo_reg[axis_reg] <= div_rsp.quot;
                    end
                end
            end
            S_BOX:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lo_idx_reg[k] <= lo_c[k][IDX_W-1:0];
                    hi_idx_reg[k] <= hi_c[k][IDX_W-1:0];
                end
            end
            S_START:
            begin
                unique case (axis_reg)
                    AXIS_X: dx_reg <= d_start;
                    AXIS_Y:
                    begin
                        dy_reg  <= d_start;
                        dy0_reg <= d_start;
                    end
                    AXIS_Z: dz0_reg <= d_start;
                    default: ;
                endcase
                if (axis_reg == AXIS_Z)
                begin
                    x_reg <= lo_idx_reg[0];
                    y_reg <= lo_idx_reg[1];
                end
            end
            S_XSQ:
            begin
                dx2_reg <= $unsigned(sq_prod);
            end
            S_ROW:
            begin
                sq_reg   <= $unsigned(sq_prod);
                mask_reg <= '0;
                z_reg    <= lo_idx_reg[2];
                dz_reg   <= dz0_reg;
            end
            S_SXY:
            begin
                sxy_reg <= {1'b0, dx2_reg} + {1'b0, sq_reg};
            end
            S_ZWALK:
            begin
                // issue stage squares dz, test stage sets the row bit
                if (!zi_done_reg)
                begin
                    sq_reg   <= $unsigned(sq_prod);
                    p1_z_reg <= z_reg;
                    dz_reg   <= dz_reg + len_s;
                    if (z_reg != hi_idx_reg[2])
                    begin
                        z_reg <= z_reg + 1'b1;
                    end
                end
                if (p1_valid_reg && hit)
                begin
                    mask_reg[p1_z_reg] <= 1'b1;
                end
            end
            S_WB:
            begin
                if (y_reg == hi_idx_reg[1])
                begin
                    y_reg  <= lo_idx_reg[1];
                    dy_reg <= dy0_reg;
                    x_reg  <= x_reg + 1'b1;
                    dx_reg <= dx_reg + len_s;
                end
                else
                begin
                    y_reg  <= y_reg + 1'b1;
                    dy_reg <= dy_reg + len_s;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - 1){1'b0}}, out_occ_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule

[sv/svm_checker.sv]
`timescale 1ns / 1ps
// svm_checker: port-level assertions for sphere_voxel_marker_unit, bound below
// depends on svm_pkg (item kind codes)

module svm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [svm_pkg::FUNC_W-1:0]    s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [svm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [svm_pkg::FUNC_W-1:0]    m_axis_tuser
);
    import svm_pkg::*;

    // only a read can report an occupied voxel
    a_occ_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser == FUNC_READ)
        else $error("occupied set on a non-read result");

    // one item at a time: acceptance drops ready
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while another was in flight");

    // a clear holds off input once its sweep is under way
    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_CLEAR |-> ##2 !s_axis_tready)
        else $error("input taken during clearing sweep");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind sphere_voxel_marker_unit svm_checker u_svm_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for sphere_voxel_marker_unit, one file
// depends on svm_pkg and the rtl of the block; mirrors the voxel map in a scoreboard class

module testbench;

    import svm_pkg::*;

    localparam int GRID = 64;

    // kind code the block does not use, it must still echo it
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // one item as it travels on s_axis
    typedef struct packed {
        logic [FUNC_W-1:0]         kind;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [RIDX_W-1:0]         rx;
        logic [RIDX_W-1:0]         ry;
        logic [RIDX_W-1:0]         rz;
    } voxel_item_t;

    // one result as it should come out on m_axis
    typedef struct packed {
        logic              occupied;
        logic [FUNC_W-1:0] kind;
    } voxel_result_t;

    // keeps its own copy of the occupancy map and the three registers,
    // works out the result of every accepted item and checks what comes back
    class voxel_scoreboard #(parameter int DIM = 64);

        bit            voxel_bits [DIM*DIM*DIM];
        int            origin;
        int            length;
        int            radius;
        voxel_result_t due_results [$];
        int            mismatches;
        int            results_seen;

        function new();
            wipe_map();
            origin       = int'(ORIGIN_RST);
            length       = int'(LENGTH_RST);
            radius       = int'(RADIUS_RST);
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void wipe_map();
            for (int k = 0; k < DIM*DIM*DIM; k++)
                voxel_bits[k] = 1'b0;
        endfunction

        function int cell_of(input int x, input int y, input int z);
            return (x * DIM + y) * DIM + z;
        endfunction

        function void set_reg(input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_ORIGIN: origin = int'($signed(data));
                REG_LENGTH: length = int'(data[LEN_W-1:0]);
                REG_RADIUS: radius = int'(data[RAD_W-1:0]);
                default: ;
            endcase
        endfunction

        // set every voxel of the box whose corner lies within the radius
        function void mark_sphere(input int cx, input int cy, input int cz);
            int     ctr [3];
            int     lo [3];
            int     hi [3];
            int     rel;
            int     a;
            longint r2;
            longint dx;
            longint dy;
            longint dz;
            if (length == 0)
                return;
            ctr[0] = cx;
            ctr[1] = cy;
            ctr[2] = cz;
            r2 = longint'(radius) * longint'(radius);
            for (a = 0; a < 3; a++)
            begin
                rel   = ctr[a] - origin;
                lo[a] = (rel - radius) / length;
                hi[a] = (rel + radius) / length + 1;
                if (lo[a] < 0)
                    lo[a] = 0;
                if (hi[a] > DIM - 1)
                    hi[a] = DIM - 1;
                if (lo[a] > hi[a])
                    return;
            end
            for (int x = lo[0]; x <= hi[0]; x++)
            begin
                dx = longint'(origin) + longint'(length) * x - cx;
                for (int y = lo[1]; y <= hi[1]; y++)
                begin
                    dy = longint'(origin) + longint'(length) * y - cy;
                    for (int z = lo[2]; z <= hi[2]; z++)
                    begin
                        dz = longint'(origin) + longint'(length) * z - cz;
                        if (dx * dx + dy * dy + dz * dz <= r2)
                            voxel_bits[cell_of(x, y, z)] = 1'b1;
                    end
                end
            end
        endfunction

        function void take_item(input voxel_item_t it);
            voxel_result_t r;
            r.occupied = 1'b0;
            r.kind     = it.kind;
            case (it.kind)
                FUNC_MARK:
                    mark_sphere($signed(it.cx), $signed(it.cy), $signed(it.cz));
                FUNC_READ:
                    if (it.rx < DIM && it.ry < DIM && it.rz < DIM)
                        r.occupied = voxel_bits[cell_of(it.rx, it.ry, it.rz)];
                FUNC_CLEAR:
                    wipe_map();
                default: ;
            endcase
            due_results.push_back(r);
        endfunction

        task report(input string msg);
            $display("mismatch at result %0d: %s", results_seen, msg);
            mismatches++;
        endtask

        task check_result(input logic [M_TDATA_W-1:0] data,
                          input logic [FUNC_W-1:0]    kind);
            voxel_result_t want;
            results_seen++;
            if (due_results.size() == 0)
            begin
                report($sformatf("result with nothing outstanding, tdata %0h tuser %0d",
                                 data, kind));
                return;
            end
            want = due_results.pop_front();
            if (data !== {{(M_TDATA_W-1){1'b0}}, want.occupied})
                report($sformatf("tdata %0h, occupied should be %0d", data, want.occupied));
            if (kind !== want.kind)
                report($sformatf("done_kind %0d, should be %0d", kind, want.kind));
        endtask

    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // block inputs, known from time zero
    logic                   s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [FUNC_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

    // block outputs
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [FUNC_W-1:0]      m_axis_tuser;

    sphere_voxel_marker_unit #(
        .GRID_DIM (GRID)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    voxel_scoreboard #(GRID) board;

    // register values as last written, used to aim the random stimulus
    int cur_origin = int'(ORIGIN_RST);
    int cur_len    = int'(LENGTH_RST);
    int cur_rad    = int'(RADIUS_RST);

    // centre of the most recent mark, reads are steered near it
    int last_cx = 0;
    int last_cy = 0;
    int last_cz = 0;

    // items left in the current sender burst
    int burst_left = 0;

    // receiver: stall mode held for a random stretch, then redrawn
    // mode 0 never stalls, mode 1 stalls half the time, mode 2 mostly stalls
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 96);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // result side monitor, values read here are the ones before the edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    function automatic voxel_item_t make_item(input logic [FUNC_W-1:0] kind,
                                              input int cx, input int cy, input int cz,
                                              input int rx, input int ry, input int rz);
        voxel_item_t it;
        it.kind = kind;
        it.cx   = cx[COORD_W-1:0];
        it.cy   = cy[COORD_W-1:0];
        it.cz   = cz[COORD_W-1:0];
        it.rx   = rx[RIDX_W-1:0];
        it.ry   = ry[RIDX_W-1:0];
        it.rz   = rz[RIDX_W-1:0];
        return it;
    endfunction

    // coordinate near the grid most of the time, anything at all otherwise
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int v;
        if ($urandom_range(0, 3) == 0)
            return COORD_W'($urandom);
        v = cur_origin - cur_rad + int'($urandom_range(0, GRID * cur_len + 2 * cur_rad));
        return v[COORD_W-1:0];
    endfunction

    // voxel index near a coordinate half the time, uniform otherwise or when the voxel length is zero
    function automatic logic [RIDX_W-1:0] pick_index(input int c);
        int idx;
        if (cur_len == 0 || $urandom_range(0, 1) == 0)
            return RIDX_W'($urandom_range(0, GRID - 1));
        idx = (c - cur_origin) / cur_len + int'($urandom_range(0, 8)) - 4;
        if (idx < 0)
            idx = 0;
        if (idx > GRID - 1)
            idx = GRID - 1;
        return idx[RIDX_W-1:0];
    endfunction

    // mostly marks and reads, a few clears and spare codes
    function automatic voxel_item_t random_item();
        voxel_item_t it;
        int          roll;
        it.cx = COORD_W'($urandom);
        it.cy = COORD_W'($urandom);
        it.cz = COORD_W'($urandom);
        it.rx = RIDX_W'($urandom);
        it.ry = RIDX_W'($urandom);
        it.rz = RIDX_W'($urandom);
        roll  = $urandom_range(0, 99);
        if (roll < 45)
        begin
            it.kind = FUNC_MARK;
            it.cx   = pick_coord();
            it.cy   = pick_coord();
            it.cz   = pick_coord();
            last_cx = $signed(it.cx);
            last_cy = $signed(it.cy);
            last_cz = $signed(it.cz);
        end
        else if (roll < 93)
        begin
            it.kind = FUNC_READ;
            it.rx   = pick_index(last_cx);
            it.ry   = pick_index(last_cy);
            it.rz   = pick_index(last_cz);
        end
        else if (roll < 97)
        begin
            it.kind = FUNC_CLEAR;
        end
        else
        begin
            it.kind = FUNC_SPARE;
        end
        return it;
    endfunction

    // one s_axis transaction, with burst and gap handling in front of it;
    // the prediction is taken at the edge where the item is accepted
    task automatic send_item(input voxel_item_t it);
        logic [S_TDATA_W-1:0] payload;
        int                   gap;
        if (burst_left == 0)
        begin
            // a third of the bursts run straight into the next one
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0)
                s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        payload = '0;
        payload[CX_LSB +: COORD_W] = it.cx;
        payload[CY_LSB +: COORD_W] = it.cy;
        payload[CZ_LSB +: COORD_W] = it.cz;
        payload[RX_LSB +: RIDX_W]  = it.rx;
        payload[RY_LSB +: RIDX_W]  = it.ry;
        payload[RZ_LSB +: RIDX_W]  = it.rz;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= it.kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.take_item(it);
    endtask

    // hold the sender off until every expected result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.due_results.size() != 0)
            @(posedge clk);
    endtask

    // all three registers on consecutive edges, only while the block idles
    task automatic write_config(input int org, input int len, input int rad);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_ORIGIN;
        cfg_wdata <= org[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_addr  <= REG_LENGTH;
        cfg_wdata <= {1'b0, len[LEN_W-1:0]};
        @(posedge clk);
        cfg_addr  <= REG_RADIUS;
        cfg_wdata <= {1'b0, rad[RAD_W-1:0]};
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(REG_ORIGIN, org[CFG_DATA_W-1:0]);
        board.set_reg(REG_LENGTH, {1'b0, len[LEN_W-1:0]});
        board.set_reg(REG_RADIUS, {1'b0, rad[RAD_W-1:0]});
        cur_origin = int'($signed(org[CFG_DATA_W-1:0]));
        cur_len    = len & 32'h7fff;
        cur_rad    = rad & 32'h7fff;
    endtask

    task automatic run_phase(input int org, input int len, input int rad, input int count);
        write_config(org, len, rad);
        repeat (count) send_item(random_item());
        wait_drained();
    endtask

    initial
    begin
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the reset register values: origin -32, 1 A voxels, 3 A radius
        // the block clears its map after reset, so the first read must be empty
        send_item(make_item(FUNC_READ, 0, 0, 0, 0, 0, 0));
        // sphere around voxel 32 on each axis
        send_item(make_item(FUNC_MARK, 0, 0, 0, 63, 63, 63));
        send_item(make_item(FUNC_READ, 0, 0, 0, 32, 32, 32));
        // exactly on the radius counts as inside, one further out does not
        send_item(make_item(FUNC_READ, 0, 0, 0, 35, 32, 32));
        send_item(make_item(FUNC_READ, 0, 0, 0, 36, 32, 32));
        send_item(make_item(FUNC_READ, 0, 0, 0, 34, 34, 32));
        // boxes entirely above and below the grid
        send_item(make_item(FUNC_MARK, 32767, 32767, 32767, 0, 0, 0));
        send_item(make_item(FUNC_MARK, -32768, -32768, -32768, 0, 0, 0));
        // centre on the grid corner, box half outside
        send_item(make_item(FUNC_MARK, -8192, -8192, -8192, 0, 0, 0));
        send_item(make_item(FUNC_READ, 0, 0, 0, 0, 0, 0));
        // near the top face
        send_item(make_item(FUNC_MARK, 8000, -300, 7936, 0, 0, 0));
        send_item(make_item(FUNC_READ, 0, 0, 0, 63, 30, 63));
        send_item(make_item(FUNC_READ, 0, 0, 0, 63, 63, 63));
        // negative offset from the origin, box bound truncates toward zero
        send_item(make_item(FUNC_MARK, -8292, 100, -100, 0, 0, 0));
        send_item(make_item(FUNC_READ, 0, 0, 0, 0, 32, 32));
        // spare kind code, full-scale fields everywhere
        send_item(make_item(FUNC_SPARE, 32767, -32768, -1, 63, 0, 63));
        // clear then confirm the centre voxel is gone
        send_item(make_item(FUNC_CLEAR, -1, -1, -1, 63, 63, 63));
        send_item(make_item(FUNC_READ, 0, 0, 0, 32, 32, 32));
        // fractional centre, corners not on the voxel lattice
        send_item(make_item(FUNC_MARK, 127, -129, 255, 0, 0, 0));
        send_item(make_item(FUNC_READ, 0, 0, 0, 32, 31, 33));
        send_item(make_item(FUNC_READ, 0, 0, 0, 33, 31, 33));
        wait_drained();

        // random phases, each on its own register setting
        run_phase(-8192, 256, 768, 150);
        run_phase(0, 128, 300, 120);
        // lowest origin, 4 A voxels cover the whole coordinate range
        run_phase(-32768, 1024, 2000, 120);
        // every register at its top value, box never exceeds three per axis
        run_phase(32767, 32767, 32767, 80);
        // zero voxel length: marks leave the map alone
        run_phase(1000, 0, 5000, 40);
        // unit voxels and zero radius: only exact lattice hits are set
        run_phase(-40, 1, 0, 100);
        run_phase(-4000, 512, 1500, 140);

        // nothing outstanding now, leave room for anything spurious
        repeat (64) @(posedge clk);
        if (board.mismatches == 0 && board.due_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // hang guard: the limit is several times the worst case, in which every item
    // is a full clear behind a stalled receiver
    initial
    begin
        #200ms;
        $display("testbench failed");
        $finish;
    end

endmodule

[filelist.f]
sv/svm_pkg.sv
sv/svm_ram.sv
sv/svm_divider.sv
sv/sphere_voxel_marker_unit.sv
sv/svm_checker.sv
tb/sv/testbench.sv
